### hdl/crv_pkg.sv
package crv_pkg;

  localparam int ID_MAX_LEN = 32;
  localparam int CNT_W      = $clog2(ID_MAX_LEN + 1);
  localparam int CFG_AW     = 8;
  localparam int CFG_DW     = 32;

  localparam logic [31:0] MAGIC_RST   = 32'h4244_4944;
  localparam logic [15:0] VERSION_RST = 16'd1;

  typedef enum logic [1:0] {
    REQ_HDR  = 2'd0,
    REQ_BYTE = 2'd1,
    REQ_SUM  = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_VERSION = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_COUNT   = 3'd4,
    ST_SUM     = 3'd5,
    ST_CHAR    = 3'd6
  } status_t;

  localparam logic [CFG_AW-1:0] CFG_MAGIC   = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_VERSION = CFG_AW'(1);

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
  } cfg_t;

  // digits, letters, underscore, hyphen
  function automatic logic char_allowed(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F || c == 8'h2D;
  endfunction

endpackage

### hdl/crv_in_if.sv
interface crv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] rec_magic;
  logic [15:0] rec_version;
  logic [15:0] id_length;
  logic [7:0]  id_byte;
  logic [31:0] stored_sum;

  modport source (
    output valid, req_type, rec_magic, rec_version, id_length, id_byte, stored_sum,
    input  ready
  );
  modport sink (
    input  valid, req_type, rec_magic, rec_version, id_length, id_byte, stored_sum,
    output ready
  );
endinterface

### hdl/crv_out_if.sv
interface crv_out_if;
  logic        valid;
  logic        ready;
  logic        record_ok;
  logic [2:0]  status;
  logic [31:0] computed_sum;

  modport source (output valid, record_ok, status, computed_sum, input ready);
  modport sink (input valid, record_ok, status, computed_sum, output ready);
endinterface

### hdl/crv_cfg_if.sv
interface crv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [crv_pkg::CFG_AW-1:0]  addr;
  logic [crv_pkg::CFG_DW-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### hdl/crv_cfg_regs.sv
module crv_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  crv_cfg_if.sink       cfg_wr,
  output crv_pkg::cfg_t cfg
);

  crv_pkg::cfg_t cfg_r;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic   <= crv_pkg::MAGIC_RST;
      cfg_r.version <= crv_pkg::VERSION_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.addr)
        crv_pkg::CFG_MAGIC:   cfg_r.magic   <= cfg_wr.data[31:0];
        crv_pkg::CFG_VERSION: cfg_r.version <= cfg_wr.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/config_record_validator.sv
// A checksum request's result is registered and presented in the cycle after it is accepted.
// Throughput: 1 request per cycle while input ready is high; the hash update
// (shift, subtract, add) is combinational logic on the running state. Header
// and byte requests give no result. Input ready drops only while a result is
// held and the sink is not ready. Reset (synchronous, rst_n low): record state
// cleared, no result pending, registers return to magic 0x42444944 and version 1.
module config_record_validator (
  input  logic       clk,
  input  logic       rst_n,
  crv_in_if.sink     in_req,
  crv_out_if.source  out_res,
  crv_cfg_if.sink    cfg_wr
);

  localparam int CW = crv_pkg::CNT_W;

  crv_pkg::cfg_t cfg;

  crv_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  logic [31:0]   hash_r, hash_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   len_r, len_nxt;
  logic          magic_bad_r, magic_bad_nxt;
  logic          ver_bad_r, ver_bad_nxt;
  logic          char_bad_r, char_bad_nxt;
  logic          overrun_r, overrun_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             ok_r;
  crv_pkg::status_t status_r, status_calc;
  logic [31:0]      sum_r;

  logic in_acc;
  logic sum_acc;
  logic cnt_full;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_acc       = in_req.valid && in_req.ready;
  assign sum_acc      = in_acc && (in_req.req_type == crv_pkg::REQ_SUM);
  assign cnt_full     = cnt_r >= CW'(crv_pkg::ID_MAX_LEN);

  always_comb begin
    hash_nxt      = hash_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    magic_bad_nxt = magic_bad_r;
    ver_bad_nxt   = ver_bad_r;
    char_bad_nxt  = char_bad_r;
    overrun_nxt   = overrun_r;
    if (in_acc) begin
      unique case (in_req.req_type)
        crv_pkg::REQ_HDR: begin
          hash_nxt      = in_req.rec_magic ^ {16'd0, in_req.rec_version}
                          ^ {16'd0, in_req.id_length};
          cnt_nxt       = '0;
          len_nxt       = in_req.id_length;
          magic_bad_nxt = in_req.rec_magic != cfg.magic;
          ver_bad_nxt   = in_req.rec_version != cfg.version;
          char_bad_nxt  = 1'b0;
          overrun_nxt   = 1'b0;
        end
        crv_pkg::REQ_BYTE: begin
          if (cnt_full) begin
            overrun_nxt = 1'b1;
          end else begin
            hash_nxt = (hash_r << 5) - hash_r + {24'd0, in_req.id_byte};
            cnt_nxt  = cnt_r + CW'(1);
            if (16'(cnt_r) < len_r && !crv_pkg::char_allowed(in_req.id_byte)) begin
              char_bad_nxt = 1'b1;
            end
          end
        end
        crv_pkg::REQ_SUM: begin
          hash_nxt      = '0;
          cnt_nxt       = '0;
          len_nxt       = '0;
          magic_bad_nxt = 1'b0;
          ver_bad_nxt   = 1'b0;
          char_bad_nxt  = 1'b0;
          overrun_nxt   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (magic_bad_r) begin
      status_calc = crv_pkg::ST_MAGIC;
    end else if (ver_bad_r) begin
      status_calc = crv_pkg::ST_VERSION;
    end else if (len_r == 16'd0 || len_r > 16'(crv_pkg::ID_MAX_LEN)) begin
      status_calc = crv_pkg::ST_LENGTH;
    end else if (overrun_r || cnt_r != CW'(crv_pkg::ID_MAX_LEN)) begin
      status_calc = crv_pkg::ST_COUNT;
    end else if (in_req.stored_sum != hash_r) begin
      status_calc = crv_pkg::ST_SUM;
    end else if (char_bad_r) begin
      status_calc = crv_pkg::ST_CHAR;
    end else begin
      status_calc = crv_pkg::ST_OK;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (sum_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      magic_bad_r <= 1'b0;
      ver_bad_r   <= 1'b0;
      char_bad_r  <= 1'b0;
      overrun_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      magic_bad_r <= magic_bad_nxt;
      ver_bad_r   <= ver_bad_nxt;
      char_bad_r  <= char_bad_nxt;
      overrun_r   <= overrun_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_acc) begin
      ok_r     <= status_calc == crv_pkg::ST_OK;
      status_r <= status_calc;
      sum_r    <= hash_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.record_ok    = ok_r;
  assign out_res.status       = status_r;
  assign out_res.computed_sum = sum_r;

endmodule

### tb/config_record_validator_test.sv
module config_record_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]                 REQ_NONE     = 2'd3;
  localparam logic [crv_pkg::CFG_AW-1:0] CFG_UNUSED   = '1;
  localparam int                         LIMIT_CYCLES = 200000;
  localparam int                         HOLD_CYCLES  = 250;
  localparam int                         PHASE_ITEMS  = 340;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] length;
    logic [7:0]  id_byte;
    logic [31:0] sum;
  } req_t;

  typedef struct packed {
    logic             ok;
    crv_pkg::status_t status;
    logic [31:0]      sum;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  crv_in_if  in_req();
  crv_out_if out_res();
  crv_cfg_if cfg_wr();

  config_record_validator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  logic                       in_valid  = 1'b0;
  req_t                       drv_q     = '0;
  logic                       res_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [crv_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [crv_pkg::CFG_DW-1:0] cfg_data  = '0;

  assign in_req.valid       = in_valid;
  assign in_req.req_type    = drv_q.kind;
  assign in_req.rec_magic   = drv_q.magic;
  assign in_req.rec_version = drv_q.version;
  assign in_req.id_length   = drv_q.length;
  assign in_req.id_byte     = drv_q.id_byte;
  assign in_req.stored_sum  = drv_q.sum;
  assign out_res.ready      = res_ready;
  assign cfg_wr.valid       = cfg_valid;
  assign cfg_wr.addr        = cfg_addr;
  assign cfg_wr.data        = cfg_data;

  // register copies, also used to build well-formed records
  logic [31:0] want_magic   = crv_pkg::MAGIC_RST;
  logic [15:0] want_version = crv_pkg::VERSION_RST;

  // record state
  logic [31:0] rec_hash    = '0;
  logic [6:0]  rec_count   = '0;
  logic [15:0] rec_len     = '0;
  logic        magic_bad   = 1'b0;
  logic        version_bad = 1'b0;
  logic        char_bad    = 1'b0;
  logic        overrun     = 1'b0;

  req_t     pending[$];
  verdict_t verdicts_due[$];

  int  fed       = 0;
  int  errors    = 0;
  int  seen      = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  steady    = 1'b0;
  int  cycles    = 0;

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    return (h << 5) - h + {24'h0, b};
  endfunction

  function automatic bit legal_id_char(input logic [7:0] c);
    return (8'(c - 8'h30) < 8'd10) || (8'(c - 8'h41) < 8'd26) ||
           (8'(c - 8'h61) < 8'd26) || c == 8'h5F || c == 8'h2D;
  endfunction

  task automatic track_request(input req_t r);
    verdict_t v;
    case (r.kind)
      crv_pkg::REQ_HDR: begin
        rec_hash    = r.magic ^ {16'h0, r.version} ^ {16'h0, r.length};
        rec_count   = '0;
        rec_len     = r.length;
        magic_bad   = r.magic != want_magic;
        version_bad = r.version != want_version;
        char_bad    = 1'b0;
        overrun     = 1'b0;
      end
      crv_pkg::REQ_BYTE: begin
        if (rec_count >= crv_pkg::ID_MAX_LEN) begin
          overrun = 1'b1;
        end else begin
          rec_hash = hash_step(rec_hash, r.id_byte);
          if (rec_count < rec_len && !legal_id_char(r.id_byte)) char_bad = 1'b1;
          rec_count = rec_count + 7'd1;
        end
      end
      crv_pkg::REQ_SUM: begin
        if (magic_bad) v.status = crv_pkg::ST_MAGIC;
        else if (version_bad) v.status = crv_pkg::ST_VERSION;
        else if (rec_len == 0 || rec_len > crv_pkg::ID_MAX_LEN) v.status = crv_pkg::ST_LENGTH;
        else if (overrun || rec_count != crv_pkg::ID_MAX_LEN) v.status = crv_pkg::ST_COUNT;
        else if (r.sum != rec_hash) v.status = crv_pkg::ST_SUM;
        else if (char_bad) v.status = crv_pkg::ST_CHAR;
        else v.status = crv_pkg::ST_OK;
        v.ok  = v.status == crv_pkg::ST_OK;
        v.sum = rec_hash;
        verdicts_due.push_back(v);
        rec_hash    = '0;
        rec_count   = '0;
        rec_len     = '0;
        magic_bad   = 1'b0;
        version_bad = 1'b0;
        char_bad    = 1'b0;
        overrun     = 1'b0;
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_req.ready) track_request(drv_q);
      if (!in_valid || in_req.ready) begin
        if (pending.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
          drv_q    <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (out_res.valid && res_ready) begin
        seen++;
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: result with none due: ok %0b status %0d sum %h", $time,
                   out_res.record_ok, out_res.status, out_res.computed_sum);
        end else begin
          want = verdicts_due.pop_front();
          if (out_res.record_ok !== want.ok) begin
            errors++;
            $display("%0t: record_ok expected %0b actual %0b", $time, want.ok,
                     out_res.record_ok);
          end
          if (out_res.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_res.status);
          end
          if (out_res.computed_sum !== want.sum) begin
            errors++;
            $display("%0t: computed_sum expected %h actual %h", $time, want.sum,
                     out_res.computed_sum);
          end
        end
      end
      // one long hold-off so the block backs up into the request side
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && seen >= 25) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      res_ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic req_t noise_req(input logic [1:0] kind);
    req_t r;
    r.kind    = kind;
    r.magic   = $urandom;
    r.version = 16'($urandom);
    r.length  = 16'($urandom);
    r.id_byte = 8'($urandom);
    r.sum     = $urandom;
    return r;
  endfunction

  function automatic logic [7:0] id_char();
    case ($urandom_range(3))
      0: return 8'(8'h30 + $urandom_range(9));
      1: return 8'(8'h41 + $urandom_range(25));
      2: return 8'(8'h61 + $urandom_range(25));
      default: return $urandom_range(1) ? 8'h5F : 8'h2D;
    endcase
  endfunction

  task automatic queue_req(input req_t r);
    pending.push_back(r);
    if (r.kind != REQ_NONE) fed++;
  endtask

  // header, nbytes identity bytes, checksum; flip corrupts the stored sum
  task automatic add_record(input logic [31:0] m, input logic [15:0] v,
                            input logic [15:0] l, input int nbytes, input bit dirty,
                            input logic [31:0] flip);
    req_t        r;
    logic [31:0] h;
    r = noise_req(crv_pkg::REQ_HDR);
    r.magic   = m;
    r.version = v;
    r.length  = l;
    queue_req(r);
    h = m ^ {16'h0, v} ^ {16'h0, l};
    for (int i = 0; i < nbytes; i++) begin
      r = noise_req(crv_pkg::REQ_BYTE);
      if (!dirty && i < l) r.id_byte = id_char();
      queue_req(r);
      if (i < crv_pkg::ID_MAX_LEN) h = hash_step(h, r.id_byte);
    end
    r = noise_req(crv_pkg::REQ_SUM);
    r.sum = h ^ flip;
    queue_req(r);
  endtask

  task automatic random_record();
    logic [31:0] m;
    logic [15:0] v;
    logic [15:0] l;
    int          n;
    bit          dirty;
    logic [31:0] flip;
    int          pick;
    m     = want_magic;
    v     = want_version;
    l     = ($urandom_range(3) == 0) ?
            ($urandom_range(1) ? 16'd1 : 16'(crv_pkg::ID_MAX_LEN)) :
            16'($urandom_range(1, crv_pkg::ID_MAX_LEN));
    n     = crv_pkg::ID_MAX_LEN;
    dirty = 1'b0;
    flip  = '0;
    pick  = $urandom_range(99);
    if (pick >= 94) begin
      queue_req(noise_req(2'($urandom_range(3))));
    end else begin
      if (pick >= 88) dirty = 1'b1;
      else if (pick >= 81) flip = 32'h1 << $urandom_range(31);
      else if (pick >= 74) n = $urandom_range(0, crv_pkg::ID_MAX_LEN + 8);
      else if (pick >= 68) begin
        case ($urandom_range(2))
          0: l = '0;
          1: l = 16'(crv_pkg::ID_MAX_LEN + 1);
          default: l = 16'($urandom_range(crv_pkg::ID_MAX_LEN + 1, 65535));
        endcase
      end
      else if (pick >= 62) v = 16'($urandom);
      else if (pick >= 55) m = $urandom;
      add_record(m, v, l, n, dirty, flip);
    end
  endtask

  task automatic run_records(input int n);
    int start;
    start = fed;
    while (fed - start < n) random_record();
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [crv_pkg::CFG_AW-1:0] idx,
                         input logic [crv_pkg::CFG_DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_valid <= 1'b0;
    if (idx == crv_pkg::CFG_MAGIC) want_magic = val;
    else if (idx == crv_pkg::CFG_VERSION) want_version = val[15:0];
  endtask

  initial begin
    req_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored type, lone checksum, stray byte, each header failure
    queue_req(noise_req(REQ_NONE));
    queue_req(noise_req(crv_pkg::REQ_SUM));
    queue_req(noise_req(crv_pkg::REQ_BYTE));
    queue_req(noise_req(crv_pkg::REQ_SUM));
    add_record(~want_magic, want_version, 16'd8, 0, 1'b0, '0);
    add_record(want_magic, ~want_version, 16'd8, 0, 1'b0, '0);
    add_record(want_magic, want_version, 16'd0, 0, 1'b0, '0);
    add_record(want_magic, want_version, 16'hFFFF, 0, 1'b0, '0);
    add_record(want_magic, want_version, 16'(crv_pkg::ID_MAX_LEN + 1), 0, 1'b0, '0);
    add_record(want_magic, want_version, 16'(crv_pkg::ID_MAX_LEN), 2, 1'b1, '0);
    add_record(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 1'b0, '0);
    add_record(32'h0, 16'h0, 16'h0, 0, 1'b0, '0);

    // full records: clean, overrun, bad character, then random
    add_record(want_magic, want_version, 16'(crv_pkg::ID_MAX_LEN), crv_pkg::ID_MAX_LEN,
               1'b0, '0);
    add_record(want_magic, want_version, 16'(crv_pkg::ID_MAX_LEN),
               crv_pkg::ID_MAX_LEN + 4, 1'b0, '0);
    add_record(want_magic, want_version, 16'(crv_pkg::ID_MAX_LEN), crv_pkg::ID_MAX_LEN,
               1'b1, '0);
    run_records(PHASE_ITEMS);
    settle();

    set_reg(crv_pkg::CFG_MAGIC, '0);
    set_reg(crv_pkg::CFG_VERSION, '0);
    run_records(PHASE_ITEMS);
    settle();

    set_reg(crv_pkg::CFG_MAGIC, '1);
    set_reg(crv_pkg::CFG_VERSION, '1);
    steady = 1'b1;
    run_records(PHASE_ITEMS);
    settle();
    steady = 1'b0;

    set_reg(CFG_UNUSED, $urandom);
    set_reg(crv_pkg::CFG_MAGIC, $urandom);
    set_reg(crv_pkg::CFG_VERSION, $urandom);
    run_records(PHASE_ITEMS);
    settle();

    set_reg(crv_pkg::CFG_MAGIC, crv_pkg::MAGIC_RST);
    set_reg(crv_pkg::CFG_VERSION, {16'h0, crv_pkg::VERSION_RST});
    run_records(PHASE_ITEMS);
    settle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
